/* sv/delayed_task_queue_unit_assert.svh */
// Assertion macros used by the delayed task queue checker.
`ifndef DELAYED_TASK_QUEUE_UNIT_ASSERT_SVH
`define DELAYED_TASK_QUEUE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define DTQ_ASSERT_SAME(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DTQ_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dtq_pkg.sv */
// Package of types and constants for the delayed task queue.
`default_nettype none

package dtq_pkg;

    // Default sizing of the task table
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int DELAY_BITS_DEF  = 16;
    localparam int TASK_BITS_DEF   = 16;

    // Port field widths
    localparam int REQ_W      = 2;
    localparam int IN_DELAY_W = 16;
    localparam int IN_TASK_W  = 16;
    localparam int OUT_TASK_W = 16;
    localparam int PEND_W     = 5;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_SCHEDULE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CANCEL   = 2'd2;

    typedef struct packed {
        logic                  fired;
        logic [OUT_TASK_W-1:0] fired_task;
        logic                  last;
        logic [PEND_W-1:0]     pending;
        logic                  dropped;
    } result_t;

endpackage

`default_nettype wire

/* sv/dtq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dtq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/dtq_ctrl.sv */
// Request sequencer: appends entries, clears them on cancel, walks the table on a tick and compacts it.
`default_nettype none

module dtq_ctrl #(
    parameter int TABLE_DEPTH = dtq_pkg::TABLE_DEPTH_DEF,
    parameter int DELAY_BITS  = dtq_pkg::DELAY_BITS_DEF,
    parameter int TASK_BITS   = dtq_pkg::TASK_BITS_DEF,
    localparam int AW         = $clog2(TABLE_DEPTH),
    localparam int EW         = DELAY_BITS + TASK_BITS
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [dtq_pkg::REQ_W-1:0]         req_type,
    input  wire  [dtq_pkg::IN_DELAY_W-1:0]    delay_in,
    input  wire  [dtq_pkg::IN_TASK_W-1:0]     task_in,
    input  wire                               obuf_ready,
    output logic                              push,
    output dtq_pkg::result_t                  push_res,
    output logic                              ram_we,
    output logic [AW-1:0]                     ram_waddr,
    output logic [EW-1:0]                     ram_wdata,
    output logic                              ram_re,
    output logic [AW-1:0]                     ram_raddr,
    input  wire  [EW-1:0]                     ram_rdata
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [1:0] {ST_IDLE, ST_RESP, ST_SCAN, ST_COMPACT} state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rv_reg, rv_next;
    logic [CNT_W-1:0]   keep_reg, keep_next;
    logic [CNT_W-1:0]   zeros_reg, zeros_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    dtq_pkg::result_t   res_reg, res_next;

    logic [DELAY_BITS-1:0] rd_delay;
    logic [TASK_BITS-1:0]  rd_task;
    logic                  hit;

    function automatic dtq_pkg::result_t mk_result(
        input logic                           fired,
        input logic [dtq_pkg::OUT_TASK_W-1:0] task_id,
        input logic                           last,
        input logic [dtq_pkg::PEND_W-1:0]     pending,
        input logic                           dropped
    );
        dtq_pkg::result_t r;
        r.fired      = fired;
        r.fired_task = task_id;
        r.last       = last;
        r.pending    = pending;
        r.dropped    = dropped;
        return r;
    endfunction

    assign rd_delay = ram_rdata[EW-1:TASK_BITS];
    assign rd_task  = ram_rdata[TASK_BITS-1:0];
    assign hit      = rv_reg && (rd_delay == '0);
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        rv_next     = rv_reg;
        keep_next   = keep_reg;
        zeros_next  = zeros_reg;
        left_next   = left_reg;
        res_next    = res_reg;
        ram_we      = 1'b0;
        ram_waddr   = cnt_reg[AW-1:0];
        ram_wdata   = {DELAY_BITS'(delay_in), TASK_BITS'(task_in)};
        ram_re      = 1'b0;
        ram_raddr   = rd_idx_reg[AW-1:0];
        push        = 1'b0;
        push_res    = res_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RESP;
                    case (req_type)
                        dtq_pkg::REQ_SCHEDULE: begin
                            if (cnt_reg < DEPTH_C) begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + ONE_C;
                                res_next = mk_result(1'b0, '0, 1'b1,
                                                     dtq_pkg::PEND_W'(cnt_next), 1'b0);
                            end else begin
                                res_next = mk_result(1'b0, '0, 1'b1,
                                                     dtq_pkg::PEND_W'(cnt_reg), 1'b1);
                            end
                        end
                        dtq_pkg::REQ_TICK: begin
                            if (cnt_reg == '0) begin
                                res_next = mk_result(1'b0, '0, 1'b1, '0, 1'b0);
                            end else begin
                                state_next  = ST_SCAN;
                                rd_idx_next = '0;
                                rv_next     = 1'b0;
                                zeros_next  = '0;
                            end
                        end
                        dtq_pkg::REQ_CANCEL: begin
                            cnt_next = '0;
                            res_next = mk_result(1'b0, '0, 1'b1, '0, 1'b0);
                        end
                        default: begin
                            res_next = mk_result(1'b0, '0, 1'b1,
                                                 dtq_pkg::PEND_W'(cnt_reg), 1'b0);
                        end
                    endcase
                end
            end

            ST_RESP: begin
                if (obuf_ready) begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // First pass: count the entries that fire on this tick
            ST_SCAN: begin
                if (hit) begin
                    zeros_next = zeros_reg + ONE_C;
                end
                if (rd_idx_reg < cnt_reg) begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + ONE_C;
                    rv_next     = 1'b1;
                end else begin
                    rv_next = 1'b0;
                end
                if (rd_idx_reg == cnt_reg && rv_reg) begin
                    state_next  = ST_COMPACT;
                    rd_idx_next = '0;
                    rv_next     = 1'b0;
                    keep_next   = '0;
                    left_next   = zeros_next;
                end
            end

            // Second pass: emit fired tasks, write survivors back toward the head
            ST_COMPACT: begin
                if (!(hit && !obuf_ready)) begin
                    if (rv_reg) begin
                        if (hit) begin
                            push      = 1'b1;
                            push_res  = mk_result(1'b1, dtq_pkg::OUT_TASK_W'(rd_task),
                                                  left_reg == ONE_C,
                                                  dtq_pkg::PEND_W'(cnt_reg - zeros_reg),
                                                  1'b0);
                            left_next = left_reg - ONE_C;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = keep_reg[AW-1:0];
                            ram_wdata = {rd_delay - DELAY_BITS'(1), rd_task};
                            keep_next = keep_reg + ONE_C;
                        end
                    end
                    if (rd_idx_reg < cnt_reg) begin
                        ram_re      = 1'b1;
                        rd_idx_next = rd_idx_reg + ONE_C;
                        rv_next     = 1'b1;
                    end else begin
                        rv_next = 1'b0;
                    end
                    if (rd_idx_reg == cnt_reg && rv_reg) begin
                        cnt_next = keep_next;
                        if (zeros_reg == '0) begin
                            res_next   = mk_result(1'b0, '0, 1'b1,
                                                   dtq_pkg::PEND_W'(keep_next), 1'b0);
                            state_next = ST_RESP;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rv_reg     <= rv_next;
            rd_idx_reg <= rd_idx_next;
            keep_reg   <= keep_next;
            zeros_reg  <= zeros_next;
            left_reg   <= left_next;
            res_reg    <= res_next;
        end
    end

endmodule

`default_nettype wire

/* sv/dtq_obuf.sv */
// Output register that holds one result transaction until the sink takes it.
`default_nettype none

module dtq_obuf (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push,
    input  wire dtq_pkg::result_t push_res,
    output logic               ready,
    output logic               m_tvalid,
    input  wire                m_tready,
    output dtq_pkg::result_t   res
);

    logic             valid_reg, valid_next;
    dtq_pkg::result_t res_reg;

    assign ready      = !valid_reg || m_tready;
    assign valid_next = push || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            res_reg <= push_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign res      = res_reg;

endmodule

`default_nettype wire

/* sv/delayed_task_queue_unit.sv */
// Delayed task queue: table of countdown timers held in one RAM, walked on each tick.
// Schedule, cancel, unknown code and empty-table tick: the result is registered, then moved to
// the output register once it is ready; the next request is taken after that move.
// Tick on N > 0 entries: two walks of the table (count, then emit and compact); the next
// request is taken after both walks, and after a summary result when no task fires; output stalls add to this.
// Reset (aresetn low, synchronous) clears the entry count and output valid; RAM is kept.
`default_nettype none

module delayed_task_queue_unit #(
    parameter int TABLE_DEPTH = dtq_pkg::TABLE_DEPTH_DEF,
    parameter int DELAY_BITS  = dtq_pkg::DELAY_BITS_DEF,
    parameter int TASK_BITS   = dtq_pkg::TASK_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // delay_ticks [15:0], task_id [31:16]
    input  wire  [dtq_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type [1:0]
    input  wire  [dtq_pkg::REQ_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // fired_task [15:0], pending [20:16], dropped [21], zero fill [23:22]
    output logic [dtq_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    // fired [0]
    output logic [0:0]                       m_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = DELAY_BITS + TASK_BITS;

    logic               obuf_ready;
    logic               push;
    dtq_pkg::result_t   push_res;
    dtq_pkg::result_t   res;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [EW-1:0]      ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [EW-1:0]      ram_rdata;

    dtq_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DELAY_BITS  (DELAY_BITS),
        .TASK_BITS   (TASK_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .req_type   (s_tuser),
        .delay_in   (s_tdata[dtq_pkg::IN_DELAY_W-1:0]),
        .task_in    (s_tdata[dtq_pkg::S_TDATA_W-1:dtq_pkg::IN_DELAY_W]),
        .obuf_ready (obuf_ready),
        .push       (push),
        .push_res   (push_res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    dtq_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dtq_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_res (push_res),
        .ready    (obuf_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res      (res)
    );

    assign m_tdata = {2'b00, res.dropped, res.pending, res.fired_task};
    assign m_tlast = res.last;
    assign m_tuser = res.fired;

endmodule

`default_nettype wire

/* sv/dtq_checker.sv */
// Port-level checker for the delayed task queue, bound to the top level.
`default_nettype none
`include "delayed_task_queue_unit_assert.svh"

module dtq_checker #(
    parameter int TABLE_DEPTH = dtq_pkg::TABLE_DEPTH_DEF
) (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [dtq_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire                           m_tlast,
    input wire [0:0]                     m_tuser
);

    // Hold a stalled result transaction unchanged
    `DTQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

    // A result that reports no firing carries a zero task identifier
    `DTQ_ASSERT_SAME(a_nofire_zero, m_tvalid && !m_tuser[0], m_tdata[15:0] == 16'd0, "task id set without fired")

    // A refused schedule is a single, non-fired result reporting a full table
    `DTQ_ASSERT_SAME(a_drop_full, m_tvalid && m_tdata[21], m_tlast && !m_tuser[0] && m_tdata[20:16] == 5'(TABLE_DEPTH), "dropped result inconsistent")

    // Requests are taken one at a time
    `DTQ_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")

endmodule

bind delayed_task_queue_unit dtq_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_dtq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
